[sv/hskv_pkg.sv]
// Package: shared types and constants for the hashed string key-value table.
`default_nettype none
package hskv_pkg;
	localparam int BUCKETS_DEF       = 41;
	localparam int ENTRIES_DEF       = 64;
	localparam int MAX_KEY_BYTES_DEF = 32;

	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam logic [31:0] HASH_TOP  = 32'h8000_0000;

	localparam logic [1:0] KIND_FIND   = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_DELETE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TOOLONG = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  key_byte;
		logic        has_byte;
		logic        last;
		logic [63:0] value_in;
	} in_item_t;

	typedef struct packed {
		logic        found;
		logic [63:0] value_out;
		logic [1:0]  status;
		logic [5:0]  bucket_index;
	} out_item_t;

	// One finished key handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] hash;
		logic [8:0]  len;
		logic        too_long;
		logic [63:0] value_in;
	} job_t;
endpackage
`default_nettype wire

[sv/hskv_front.sv]
// Front end: folds key bytes into the hash, collects the key and queues finished keys.
`default_nettype none
module hskv_front
	import hskv_pkg::*;
#(
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          job_valid,
	input  wire logic     job_ready,
	output job_t          job,
	// key byte read port for the back end
	input  wire logic [KW-1:0] kb_addr,
	output logic [7:0]         kb_data
);
	logic [31:0] hash_q;
	logic [8:0]  len_q;
	logic        long_q;
	logic [7:0]  kbuf_q [MAX_KEY_BYTES];
	logic        hold_q; // a key is queued; buffer frozen until back end drops it
	job_t        job_q;
	logic        acc;
	logic [31:0] hash_nx;
	logic        store;

	// one-deep queue: a key stays in the buffer until its job is taken and done
	assign in_ready  = !hold_q;
	assign acc       = in_valid && in_ready;
	assign hash_nx   = in_data.has_byte ? (hash_q * 32'd33 + {24'd0, in_data.key_byte}) : hash_q;
	assign store     = in_data.has_byte && (len_q < 9'(MAX_KEY_BYTES));
	assign job_valid = hold_q;
	assign job       = job_q;

	always_ff @(posedge clk) begin
		if (acc && store) kbuf_q[len_q[KW-1:0]] <= in_data.key_byte;
		kb_data <= kbuf_q[kb_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			len_q  <= '0;
			long_q <= 1'b0;
			hold_q <= 1'b0;
			job_q  <= '0;
		end else begin
			if (job_ready && hold_q) hold_q <= 1'b0;
			if (acc) begin
				if (in_data.last) begin
					hold_q         <= 1'b1;
					job_q.kind     <= in_data.kind;
					job_q.hash     <= hash_nx | HASH_TOP;
					job_q.len      <= store ? len_q + 9'd1 : len_q;
					job_q.too_long <= long_q || (in_data.has_byte && !store);
					job_q.value_in <= in_data.value_in;
					hash_q <= HASH_SEED;
					len_q  <= '0;
					long_q <= 1'b0;
				end else begin
					hash_q <= hash_nx;
					if (store) len_q <= len_q + 9'd1;
					else if (in_data.has_byte) long_q <= 1'b1;
				end
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) hold_q |-> !in_ready)
		else $error("front accepted while a key is queued");
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= 9'(MAX_KEY_BYTES))
		else $error("key length beyond buffer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_data.last) |=> (len_q == '0 && hash_q == HASH_SEED))
		else $error("collector not cleared after last");
endmodule
`default_nettype wire

[sv/hskv_back.sv]
// Back end: bucket reduction, entry scan with byte compare, and table update.
`default_nettype none
module hskv_back
	import hskv_pkg::*;
#(
	parameter int BUCKETS       = BUCKETS_DEF,
	parameter int ENTRIES       = ENTRIES_DEF,
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
	localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
	localparam int EW = $clog2(ENTRIES),
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  job_valid,
	output logic       job_ready,
	input  wire job_t  job,
	output logic [KW-1:0] kb_addr,
	input  wire logic [7:0] kb_data,
	output logic       out_valid,
	input  wire logic  out_ready,
	output out_item_t  out_data
);
	localparam logic [3:0] S_IDLE = 4'd0, S_MOD = 4'd1, S_ENT = 4'd2, S_RD = 4'd3,
		S_CMP = 4'd4, S_NEXT = 4'd5, S_ACT = 4'd6, S_WR = 4'd7, S_OUT = 4'd8,
		S_CHK = 4'd9;
	localparam logic [31:0] BK = 32'(BUCKETS);
	localparam int AW = $clog2(ENTRIES * MAX_KEY_BYTES);
	// reciprocal of the bucket count, exact for every 32-bit hash
	localparam int BL = $clog2(BUCKETS);
	localparam logic [32:0] RECIP =
		33'(((64'd1 << (32 + BL)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	logic [3:0]    state_q;
	logic [31:0]   rem_q;
	logic [64:0]   prod_q;
	logic [64:0]   prod_nx;
	logic [31:0]   quot;
	logic [EW:0]   ent_q;
	logic [8:0]    bi_q;
	logic [8:0]    bim1;
	logic          hit_q;
	logic [EW-1:0] hidx_q;
	logic          free_q;
	logic [EW-1:0] fidx_q;
	logic          valid_q [ENTRIES];
	logic [BW-1:0] ebkt_mem [ENTRIES];
	logic [8:0]    elen_mem [ENTRIES];
	logic [63:0]   eval_mem [ENTRIES];
	logic [7:0]    ekey_mem [ENTRIES*MAX_KEY_BYTES];
	logic          ev_rd;
	logic [BW-1:0] ebkt_rd;
	logic [8:0]    elen_rd;
	logic [7:0]    ekey_rd;
	logic [63:0]   eval_rd;
	logic          wr_key;
	logic          ins_new;
	logic [EW-1:0] ei;
	logic [AW-1:0] kaddr;
	logic [AW-1:0] waddr;
	out_item_t     res_q;
	logic          pend_q;

	assign ei        = ent_q[EW-1:0];
	assign kb_addr   = bi_q[KW-1:0];
	assign bim1      = bi_q - 9'd1;
	assign kaddr     = AW'(ei) * AW'(MAX_KEY_BYTES) + AW'(bi_q[KW-1:0]);
	assign waddr     = AW'(ei) * AW'(MAX_KEY_BYTES) + AW'(bim1[KW-1:0]);
	assign job_ready = (state_q == S_OUT) && !pend_q;
	assign out_valid = pend_q;
	assign out_data  = res_q;
	assign prod_nx   = {33'd0, job.hash} * {33'd0, RECIP[31:0]}
		+ (RECIP[32] ? {1'b0, job.hash, 32'd0} : 65'd0);
	assign quot      = 32'(prod_q >> (32 + BL));
	// kb_data is a registered read of kb_addr, so the copy writes the byte of the previous index
	assign wr_key    = (state_q == S_WR) && (job.kind == KIND_INSERT)
		&& (bi_q != 9'd0) && (bi_q <= job.len);
	assign ins_new   = (state_q == S_ACT) && job.kind == KIND_INSERT && !job.too_long
		&& !hit_q && free_q;

	// entry fields and key bytes: memories, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_key) ekey_mem[waddr] <= kb_data;
		ekey_rd <= ekey_mem[kaddr];
		if (ins_new) begin
			ebkt_mem[fidx_q] <= rem_q[BW-1:0];
			elen_mem[fidx_q] <= job.len;
		end
		ebkt_rd <= ebkt_mem[ei];
		elen_rd <= elen_mem[ei];
		ev_rd   <= valid_q[ei];
		if (state_q == S_ACT && job.kind == KIND_INSERT && !job.too_long && (hit_q || free_q))
			eval_mem[hit_q ? hidx_q : fidx_q] <= job.value_in;
		eval_rd <= eval_mem[hidx_q];
	end

	// S_IDLE/S_MOD: reciprocal multiply, then subtract quotient times bucket count
	// S_ENT/S_CHK: read one entry, then check it; S_RD/S_CMP/S_NEXT compare one key byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= 1'b0;
			for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
			rem_q <= '0; prod_q <= '0; ent_q <= '0; bi_q <= '0;
			hit_q <= 1'b0; hidx_q <= '0; free_q <= 1'b0; fidx_q <= '0; res_q <= '0;
		end else begin
			if (pend_q && out_ready) pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (job_valid && !pend_q) begin
					prod_q  <= prod_nx;
					state_q <= S_MOD;
				end
				S_MOD: begin
					rem_q   <= job.hash - quot * BK;
					state_q <= job.too_long ? S_ACT : S_ENT;
					ent_q <= '0; hit_q <= 1'b0; free_q <= 1'b0;
				end
				S_ENT: begin
					if (ent_q == (EW+1)'(ENTRIES) || hit_q) state_q <= S_ACT;
					else state_q <= S_CHK;
				end
				S_CHK: begin
					if (!ev_rd && !free_q) begin
						free_q <= 1'b1; fidx_q <= ei;
					end
					if (ev_rd && ebkt_rd == rem_q[BW-1:0] && elen_rd == job.len) begin
						bi_q <= '0; state_q <= S_RD;
					end else begin
						ent_q <= ent_q + (EW+1)'(1); state_q <= S_ENT;
					end
				end
				S_RD: if (bi_q == job.len) begin
					hit_q <= 1'b1; hidx_q <= ei; state_q <= S_ACT;
				end else state_q <= S_CMP;
				S_CMP: state_q <= S_NEXT;
				S_NEXT: if (ekey_rd != kb_data) begin
					ent_q <= ent_q + (EW+1)'(1); state_q <= S_ENT;
				end else begin
					bi_q <= bi_q + 9'd1; state_q <= S_RD;
				end
				S_ACT: begin
					res_q.bucket_index <= 6'(rem_q);
					res_q.value_out <= '0;
					res_q.found <= job.too_long ? 1'b0 : hit_q;
					res_q.status <= job.too_long ? ST_TOOLONG :
						(job.kind == KIND_INSERT && !hit_q && !free_q) ? ST_FULL : ST_OK;
					if (job.too_long) begin
						bi_q <= '0; state_q <= S_OUT;
					end else if (ins_new) begin
						valid_q[fidx_q] <= 1'b1;
						ent_q <= {1'b0, fidx_q};
						bi_q <= '0; state_q <= S_WR;
					end else if (job.kind != KIND_INSERT && job.kind != KIND_DELETE && hit_q) begin
						state_q <= S_WR; bi_q <= 9'(MAX_KEY_BYTES); // wait for value read
					end else begin
						if (job.kind == KIND_DELETE && hit_q) valid_q[hidx_q] <= 1'b0;
						bi_q <= '0; state_q <= S_OUT;
					end
				end
				S_WR: begin
					// key copy: one byte written per step, trailing the read index by one
					if (bi_q >= job.len) begin
						if (job.kind != KIND_INSERT) res_q.value_out <= eval_rd;
						state_q <= S_OUT;
					end else bi_q <= bi_q + 9'd1;
				end
				S_OUT: if (!pend_q) begin
					pend_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_ACT) |-> (rem_q < BK))
		else $error("bucket reduction incomplete");
	assert property (@(posedge clk) disable iff (!arst_n) job_ready |-> job_valid)
		else $error("job released without a job");
endmodule
`default_nettype wire

[sv/hashed_string_key_value_table_unit.sv]
// Top level: hashed string key-value table, front collector plus back table engine.
// Usage:
//  - in channel (in_valid/in_ready/in_data): at most one key byte per transfer; last ends
//    the key and starts find, insert or delete as given by kind.
//  - out channel (out_valid/out_ready/out_data): one result per key.
//  - After a last item the back end starts, reduces the hash mod BUCKETS (reciprocal
//    multiply, then subtract), then scans the entry store, reading and checking one
//    entry at a time and comparing key bytes for a candidate of matching bucket and
//    length; then it acts, copies a new key or fetches a found value, and posts the result.
//  - The front accepts no further item while a finished key waits for the back end,
//    since the back end reads the key bytes from the front's buffer.
//  - Reset empties the table at once (valid flags cleared); no clearing pass.
//  - If the receiver stalls, the result is held in the output register and the
//    back end waits before starting the next key.
`default_nettype none
module hashed_string_key_value_table_unit
	import hskv_pkg::*;
#(
	parameter int BUCKETS       = BUCKETS_DEF,
	parameter int ENTRIES       = ENTRIES_DEF,
	parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);
	localparam int KW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	logic          job_valid, job_ready;
	job_t          job;
	logic [KW-1:0] kb_addr;
	logic [7:0]    kb_data;

	hskv_front #(.MAX_KEY_BYTES(MAX_KEY_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.job_valid, .job_ready, .job, .kb_addr, .kb_data
	);

	hskv_back #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_back (
		.clk, .arst_n, .job_valid, .job_ready, .job, .kb_addr, .kb_data,
		.out_valid, .out_ready, .out_data
	);
endmodule
`default_nettype wire

[tb/sv/hashed_string_key_value_table_unit_test.sv]
// Testbench: randomised key streams checked against a behavioural model of the key-value table.
`timescale 1ns / 1ps
`default_nettype none
module hashed_string_key_value_table_unit_test;
	import hskv_pkg::*;

	localparam int NBUCKETS  = BUCKETS_DEF;
	localparam int NENTRIES  = ENTRIES_DEF;
	localparam int KEYMAX    = MAX_KEY_BYTES_DEF;
	localparam int POOL_KEYS = 80;   // more distinct keys than entries, so the store fills

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	hashed_string_key_value_table_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// Table model: its own copy of the collector and of the entry store
	logic [31:0] acc_hash;
	int          acc_len;
	logic        acc_overflow;
	logic [7:0]  acc_bytes [KEYMAX];
	logic        tbl_used  [NENTRIES];
	logic [5:0]  tbl_bucket[NENTRIES];
	int          tbl_len   [NENTRIES];
	logic [7:0]  tbl_key   [NENTRIES][KEYMAX];
	logic [63:0] tbl_value [NENTRIES];

	in_item_t  pending_items[$];   // fed to the driver
	out_item_t expected_results[$];
	int        error_count;
	logic      quiet_phase;        // no idling on either side
	logic      hold_off_req;       // asks the receiver for a long stall

	// Key pool: random content, a few lengths at the edges
	logic [7:0] pool_bytes[POOL_KEYS][KEYMAX + 4];
	int         pool_len  [POOL_KEYS];

	function automatic int find_entry(logic [5:0] bkt);
		for (int i = 0; i < NENTRIES; i++) begin
			if (tbl_used[i] && tbl_bucket[i] == bkt && tbl_len[i] == acc_len) begin
				automatic bit same = 1'b1;
				for (int j = 0; j < acc_len; j++)
					if (tbl_key[i][j] != acc_bytes[j]) same = 1'b0;
				if (same) return i;
			end
		end
		return -1;
	endfunction

	// Advances the model by one accepted transfer; queues the result on a last item
	task automatic table_step(input in_item_t it);
		logic [31:0] h;
		logic [5:0]  bkt;
		out_item_t   r;
		int          hit;
		int          slot;
		if (it.has_byte) begin
			acc_hash = acc_hash * 32'd33 + {24'd0, it.key_byte};
			if (acc_len < KEYMAX) begin
				acc_bytes[acc_len] = it.key_byte;
				acc_len++;
			end else begin
				acc_overflow = 1'b1;
			end
		end
		if (!it.last) return;
		h   = acc_hash | HASH_TOP;
		bkt = 6'(h % NBUCKETS);
		r   = '0;
		r.bucket_index = bkt;
		if (acc_overflow) begin
			r.status = ST_TOOLONG;
		end else begin
			hit     = find_entry(bkt);
			r.found = (hit >= 0);
			if (it.kind == KIND_INSERT) begin
				if (hit >= 0) begin
					tbl_value[hit] = it.value_in;
				end else begin
					slot = -1;
					for (int i = 0; i < NENTRIES; i++)
						if (!tbl_used[i] && slot < 0) slot = i;
					if (slot < 0) begin
						r.status = ST_FULL;
					end else begin
						tbl_used[slot]   = 1'b1;
						tbl_bucket[slot] = bkt;
						tbl_len[slot]    = acc_len;
						for (int j = 0; j < acc_len; j++) tbl_key[slot][j] = acc_bytes[j];
						tbl_value[slot]  = it.value_in;
					end
				end
			end else if (it.kind == KIND_DELETE) begin
				if (hit >= 0) tbl_used[hit] = 1'b0;
			end else if (hit >= 0) begin
				// find, and the unused code which behaves as find
				r.value_out = tbl_value[hit];
			end
		end
		expected_results.push_back(r);
		acc_hash     = HASH_SEED;
		acc_len      = 0;
		acc_overflow = 1'b0;
	endtask

	// Queues one key as a byte stream; the operation rides on every key byte and the last item
	task automatic queue_key(input logic [1:0] op, input logic [7:0] kb[], input int n,
			input logic [63:0] val, input bit noisy);
		in_item_t it;
		for (int i = 0; i < n; i++) begin
			it          = '0;
			it.kind     = op;
			it.key_byte = kb[i];
			it.has_byte = 1'b1;
			it.value_in = {$urandom, $urandom};
			it.last     = (i == n - 1) && !noisy;
			if (it.last) it.value_in = val;
			pending_items.push_back(it);
			// filler transfers with has_byte low must not alter the key
			if (noisy && $urandom_range(0, 5) == 0) begin
				it          = '0;
				it.kind     = 2'($urandom);
				it.key_byte = 8'($urandom);
				pending_items.push_back(it);
			end
		end
		if (n == 0 || noisy) begin
			it          = '0;
			it.kind     = op;
			it.key_byte = 8'($urandom);
			it.last     = 1'b1;
			it.value_in = val;
			pending_items.push_back(it);
		end
	endtask

	task automatic queue_pool_key(input logic [1:0] op, input int k, input logic [63:0] val);
		logic [7:0] kb[];
		kb = new[pool_len[k]];
		for (int i = 0; i < pool_len[k]; i++) kb[i] = pool_bytes[k][i];
		queue_key(op, kb, pool_len[k], val, $urandom_range(0, 3) == 0);
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
	endtask

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Offer accepted at the last rising edge
	logic in_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;
		end
	end

	// Driver: presents the head of the pending queue, idles in bursts
	int send_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_taken) begin
			// hold the offer until accepted
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			send_gap <= $urandom_range(0, 11);
		end else if (pending_items.size() != 0) begin
			in_valid <= 1'b1;
			in_data  <= pending_items.pop_front();
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver readiness: random stall bursts, plus the long hold-off on request
	int recv_gap;
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap  <= 0;
		end else if (hold_off_req) begin
			out_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			out_ready <= 1'b0;
			recv_gap  <= recv_gap - 1;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			out_ready <= 1'b0;
			recv_gap  <= $urandom_range(0, 11);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: model steps on each input transfer, results compared on each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) table_step(in_data);
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result with nothing expected: %p", out_data);
					error_count++;
				end else begin
					automatic out_item_t e = expected_results.pop_front();
					if (out_data.found !== e.found) begin
						$error("found: expected %0d, got %0d", e.found, out_data.found);
						error_count++;
					end
					if (out_data.value_out !== e.value_out) begin
						$error("value_out: expected %h, got %h", e.value_out, out_data.value_out);
						error_count++;
					end
					if (out_data.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, out_data.status);
						error_count++;
					end
					if (out_data.bucket_index !== e.bucket_index) begin
						$error("bucket_index: expected %0d, got %0d",
							e.bucket_index, out_data.bucket_index);
						error_count++;
					end
				end
			end
		end
	end

	// Long hold-off: counted here while the driver keeps offering
	int hold_cycles;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_cycles <= 0;
		end else if (hold_off_req) begin
			hold_cycles <= hold_cycles + 1;
		end
	end

	// Stimulus
	initial begin
		logic [7:0] kb[];
		in_item_t   it;
		int         k;
		int         op_sel;
		error_count   = 0;
		quiet_phase   = 1'b0;
		hold_off_req  = 1'b0;
		acc_hash      = HASH_SEED;
		acc_len       = 0;
		acc_overflow  = 1'b0;
		for (int i = 0; i < NENTRIES; i++) tbl_used[i] = 1'b0;
		for (int p = 0; p < POOL_KEYS; p++) begin
			case (p)
				0: pool_len[p] = 0;
				1: pool_len[p] = 1;
				2: pool_len[p] = KEYMAX;
				default: pool_len[p] = $urandom_range(1, 6);
			endcase
			for (int i = 0; i < KEYMAX + 4; i++) pool_bytes[p][i] = 8'($urandom);
		end
		pool_bytes[1][0] = 8'hFF;
		wait (arst_n === 1'b1);

		// Directed: empty key, byte extremes, longest key, every operation, overflow
		queue_key(KIND_FIND, kb, 0, 64'd0, 0);
		queue_pool_key(KIND_INSERT, 0, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_pool_key(KIND_FIND, 0, 64'd0);
		kb = new[1]; kb[0] = 8'h00;
		queue_key(KIND_INSERT, kb, 1, 64'd0, 0);
		queue_pool_key(KIND_INSERT, 1, 64'h8000_0000_0000_0001);
		queue_pool_key(KIND_INSERT, 1, 64'h5555_AAAA_5555_AAAA);  // insert hit overwrites
		queue_pool_key(KIND_FIND, 1, 64'd0);
		queue_pool_key(KIND_INSERT, 2, 64'h0123_4567_89AB_CDEF);
		queue_pool_key(KIND_FIND, 2, 64'd0);
		queue_pool_key(2'd3, 2, 64'd0);                          // unused code acts as find
		queue_pool_key(KIND_DELETE, 2, 64'd0);
		queue_pool_key(KIND_DELETE, 2, 64'd0);                   // delete miss
		queue_pool_key(KIND_FIND, 2, 64'd0);
		kb = new[KEYMAX + 1];
		foreach (kb[i]) kb[i] = 8'($urandom);
		queue_key(KIND_INSERT, kb, KEYMAX + 1, 64'd7, 0);        // too long
		queue_key(KIND_FIND, kb, KEYMAX + 1, 64'd0, 1);
		queue_pool_key(KIND_DELETE, 0, 64'd0);                   // delete of a head entry
		queue_pool_key(KIND_FIND, 0, 64'd0);
		wait_drained();

		// Fill the store to full and probe inserts beyond it
		for (int p = 3; p < 3 + NENTRIES + 4; p++)
			queue_pool_key(KIND_INSERT, p, {$urandom, $urandom});
		// Long receiver stall while the sender keeps offering
		hold_off_req = 1'b1;
		wait (hold_cycles >= 600);
		hold_off_req = 1'b0;
		wait_drained();

		// Random: mostly well-formed keys from the pool, some noise and odd lengths
		for (int n = 0; n < 100; n++) begin
			if (n == 85) quiet_phase = 1'b1;
			op_sel = $urandom_range(0, 15);
			k      = $urandom_range(0, POOL_KEYS - 1);
			if (op_sel < 5) begin
				queue_pool_key(KIND_FIND, k, {$urandom, $urandom});
			end else if (op_sel < 10) begin
				queue_pool_key(KIND_INSERT, k, {$urandom, $urandom});
			end else if (op_sel < 14) begin
				queue_pool_key(KIND_DELETE, k, {$urandom, $urandom});
			end else if (op_sel == 14) begin
				queue_pool_key(2'd3, k, {$urandom, $urandom});
			end else begin
				kb = new[$urandom_range(KEYMAX - 1, KEYMAX + 3)];
				foreach (kb[i]) kb[i] = 8'($urandom);
				queue_key(2'($urandom), kb, kb.size(), {$urandom, $urandom}, 1'($urandom));
			end
			// keep the driver queue shallow so pacing follows the block
			while (pending_items.size() > 40) @(posedge clk);
		end
		// Cover has_byte low in a non-last transfer with every field toggled
		it = '1;
		it.has_byte = 1'b0;
		it.last     = 1'b0;
		pending_items.push_back(it);
		queue_pool_key(KIND_FIND, 1, 64'd0);
		wait_drained();
		repeat (200) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("hashed_string_key_value_table_unit_test: clean");
		end else begin
			$display("hashed_string_key_value_table_unit_test: errors");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#(8 * 3000000);
		$display("hashed_string_key_value_table_unit_test: errors");
		$finish;
	end
endmodule
`default_nettype wire

[hashed_string_key_value_table_unit.f]
sv/hskv_pkg.sv
sv/hskv_front.sv
sv/hskv_back.sv
sv/hashed_string_key_value_table_unit.sv
tb/sv/hashed_string_key_value_table_unit_test.sv
